>>> rtl/core/sdoew_pkg.sv
package sdoew_pkg;

    // Event kinds on the input stream
    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_RESP  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // Result kinds on the output stream
    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_REFUSED = 2'd2
    } kind_t;

    // Completion status of a write
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_TIMEOUT = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NODE_ID = 2'd0,
        CFG_BASE_ID = 2'd1,
        CFG_TIMEOUT = 2'd2
    } cfg_idx_t;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 128;

    localparam logic [6:0]  NODE_ID_RST   = 7'd1;
    localparam logic [10:0] BASE_ID_RST   = 11'h600;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;
    localparam logic [7:0]  CMD_EXP_WRITE = 8'h23;
    localparam logic [15:0] OBJ_BASE_IDX  = 16'h2100;
    localparam logic [31:0] ABORT_RANGE   = 32'h0609_0030;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        func_t              func;
        logic [15:0]        param_id;
        logic signed [31:0] value_fixed;
        logic [15:0]        resp_index;
        logic [7:0]         resp_subindex;
        logic               resp_is_abort;
        logic [31:0]        resp_error_code;
    } item_t;

    typedef struct packed {
        kind_t              out_kind;
        logic [10:0]        can_id;
        logic [7:0]         cmd_byte;
        logic [15:0]        obj_index;
        logic [7:0]         obj_subindex;
        logic [31:0]        data_word;
        logic [15:0]        done_param_id;
        logic signed [31:0] done_value;
        status_t            done_status;
    } result_t;

    // Tracker status seen by the top level
    typedef struct packed {
        logic        pending;
        logic [15:0] elapsed;
    } track_stat_t;

endpackage

>>> rtl/core/sdoew_in_stage.sv
module sdoew_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: param_id, value_fixed, resp_index, resp_subindex, resp_is_abort,
    //        resp_error_code, zero pad
    input  logic [sdoew_pkg::IN_TDATA_W-1:0]  s_tdata,
    // tuser: func
    input  logic [1:0]                        s_tuser,
    input  logic                              fire,
    output logic                              item_valid,
    output sdoew_pkg::item_t                  item
);
    import sdoew_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  take;

    // Free the slot when the engine consumes the held word
    assign s_tready = !valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.func            <= func_t'(s_tuser);
            item_reg.param_id        <= s_tdata[15:0];
            item_reg.value_fixed     <= s_tdata[47:16];
            item_reg.resp_index      <= s_tdata[63:48];
            item_reg.resp_subindex   <= s_tdata[71:64];
            item_reg.resp_is_abort   <= s_tdata[72];
            item_reg.resp_error_code <= s_tdata[104:73];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/sdoew_engine.sv
module sdoew_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sdoew_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sdoew_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              fire,
    input  sdoew_pkg::item_t                  item,
    output logic                              res_valid,
    output sdoew_pkg::result_t                res,
    output sdoew_pkg::track_stat_t            stat
);
    import sdoew_pkg::*;

    logic [6:0]         node_id_reg;
    logic [10:0]        base_id_reg;
    logic [15:0]        timeout_reg;

    logic               pending_reg, pending_next;
    logic [15:0]        p_index_reg, p_index_next;
    logic [7:0]         p_sub_reg, p_sub_next;
    logic [15:0]        p_param_reg, p_param_next;
    logic signed [31:0] p_value_reg, p_value_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic [15:0]        req_index;
    logic               resp_match;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= NODE_ID_RST;
            base_id_reg <= BASE_ID_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_NODE_ID: node_id_reg <= cfg_wdata[6:0];
                CFG_BASE_ID: base_id_reg <= cfg_wdata[10:0];
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign req_index  = OBJ_BASE_IDX | {8'd0, item.param_id[15:8]};
    assign resp_match = pending_reg && (item.resp_index == p_index_reg)
                        && (item.resp_subindex == p_sub_reg);

    // Decide the result and the next tracker state for the held word
    always_comb begin
        res_valid    = 1'b0;
        res          = '0;
        pending_next = pending_reg;
        p_index_next = p_index_reg;
        p_sub_next   = p_sub_reg;
        p_param_next = p_param_reg;
        p_value_next = p_value_reg;
        elapsed_next = elapsed_reg;
        case (item.func)
            FUNC_START: begin
                res_valid = 1'b1;
                if (pending_reg) begin
                    res.out_kind = KIND_REFUSED;
                end else begin
                    pending_next     = 1'b1;
                    p_index_next     = req_index;
                    p_sub_next       = item.param_id[7:0];
                    p_param_next     = item.param_id;
                    p_value_next     = item.value_fixed;
                    elapsed_next     = '0;
                    res.out_kind     = KIND_REQUEST;
                    res.can_id       = base_id_reg | {4'd0, node_id_reg};
                    res.cmd_byte     = CMD_EXP_WRITE;
                    res.obj_index    = req_index;
                    res.obj_subindex = item.param_id[7:0];
                    res.data_word    = item.value_fixed;
                end
            end
            FUNC_RESP: begin
                if (resp_match) begin
                    res_valid         = 1'b1;
                    pending_next      = 1'b0;
                    res.out_kind      = KIND_DONE;
                    res.done_param_id = p_param_reg;
                    res.done_value    = p_value_reg;
                    if (!item.resp_is_abort) begin
                        res.done_status = STAT_OK;
                    end else if (item.resp_error_code == ABORT_RANGE) begin
                        res.done_status = STAT_RANGE;
                    end else begin
                        res.done_status = STAT_UNKNOWN;
                    end
                end
            end
            FUNC_TICK: begin
                if (pending_reg) begin
                    if (elapsed_reg != TICKS_MAX) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (elapsed_next >= timeout_reg) begin
                        res_valid         = 1'b1;
                        pending_next      = 1'b0;
                        res.out_kind      = KIND_DONE;
                        res.done_param_id = p_param_reg;
                        res.done_value    = p_value_reg;
                        res.done_status   = STAT_TIMEOUT;
                    end
                end
            end
            FUNC_CLEAR: begin
                pending_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Commit the tracker state when the word is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (fire) begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            p_index_reg <= p_index_next;
            p_sub_reg   <= p_sub_next;
            p_param_reg <= p_param_next;
            p_value_reg <= p_value_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign stat.pending = pending_reg;
    assign stat.elapsed = elapsed_reg;

endmodule

>>> rtl/core/sdoew_out_stage.sv
module sdoew_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               fire,
    input  logic                               res_valid,
    input  sdoew_pkg::result_t                 res,
    output logic                               space,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: can_id, cmd_byte, obj_index, obj_subindex, data_word,
    //        done_param_id, done_value, done_status, zero pad
    output logic [sdoew_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser: out_kind
    output logic [1:0]                         m_tuser
);
    import sdoew_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] tdata_reg;
    logic [1:0]             tuser_reg;
    logic                   load;

    assign space = !valid_reg || m_tready;
    assign load  = fire && res_valid;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Pack the result word
    always_ff @(posedge aclk) begin
        if (load) begin
            tuser_reg <= res.out_kind;
            tdata_reg <= {3'd0, res.done_status, res.done_value, res.done_param_id,
                          res.data_word, res.obj_subindex, res.obj_index,
                          res.cmd_byte, res.can_id};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

>>> rtl/core/sdo_expedited_write_tracker.sv
// SDO expedited write tracker: client side of one outstanding CANopen expedited
// download. Each input word is an event chosen by tuser (start, response, tick,
// clear) and yields zero or one result word (request frame, write finished, or
// start refused). While the output is not stalled the block takes one event per
// clock: a word passes an input register, is decoded against the pending-write
// registers by combinational logic, and its result lands in an output register
// once that register has space. A stalled output holds the input, also for events
// that yield no result. Only one write is tracked at a time; a start while one is
// pending is refused. Configuration writes take effect at once and are meant to
// be issued while no events are in flight.
module sdo_expedited_write_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sdoew_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sdoew_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: param_id, value_fixed, resp_index, resp_subindex, resp_is_abort,
    //        resp_error_code, zero pad
    input  logic [sdoew_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: func
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: can_id, cmd_byte, obj_index, obj_subindex, data_word,
    //        done_param_id, done_value, done_status, zero pad
    output logic [sdoew_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser: out_kind
    output logic [1:0]                         m_tuser
);
    import sdoew_pkg::*;

    logic        item_valid;
    item_t       item;
    logic        space;
    logic        fire;
    logic        res_valid;
    result_t     res;
    track_stat_t stat;

    // Consume the held word once the output register can take its result
    assign fire = item_valid && space;

    sdoew_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sdoew_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .stat      (stat)
    );

    sdoew_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // An accepted start on an idle tracker leaves a write pending
    a_start_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.func == FUNC_START) && !stat.pending |=> stat.pending)
        else $error("start did not register a pending write");

    // A finished write can only come from a pending one
    a_done_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && (res.out_kind == KIND_DONE) |-> stat.pending)
        else $error("write finished with nothing pending");

    // A refusal only happens while a write is pending
    a_refuse_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && (res.out_kind == KIND_REFUSED) |-> stat.pending)
        else $error("start refused while idle");

    // Input backpressure only while a word is held
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid)
        else $error("input stalled with empty register");
`endif

endmodule

>>> tb/sv/sdo_expedited_write_tracker_test.sv
`timescale 1ns / 100ps

module sdo_expedited_write_tracker_test;
    import sdoew_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    // Predicted tracker state and register copies
    logic [6:0]  node_id_q   = NODE_ID_RST;
    logic [10:0] base_id_q   = BASE_ID_RST;
    logic [15:0] timeout_q   = TIMEOUT_RST;
    logic        wr_pending  = 1'b0;
    logic [15:0] wr_index    = '0;
    logic [7:0]  wr_subindex = '0;
    logic [15:0] wr_param    = '0;
    logic [31:0] wr_value    = '0;
    logic [15:0] wr_elapsed  = '0;

    result_t replies_due[$];
    int      mismatch_count = 0;
    int      events_sent    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      rx_hold_left   = 0;
    int      stall_cycles   = 0;

    sdo_expedited_write_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the tracker by one event; return 1 when it yields a result word
    function automatic bit track_write_event(input item_t ev, output result_t res);
        status_t st;
        res = '0;
        case (ev.func)
            FUNC_START: begin
                if (wr_pending) begin
                    res.out_kind = KIND_REFUSED;
                    return 1'b1;
                end
                wr_pending  = 1'b1;
                wr_index    = OBJ_BASE_IDX | {8'h00, ev.param_id[15:8]};
                wr_subindex = ev.param_id[7:0];
                wr_param    = ev.param_id;
                wr_value    = ev.value_fixed;
                wr_elapsed  = '0;
                res.out_kind     = KIND_REQUEST;
                res.can_id       = base_id_q | {4'b0000, node_id_q};
                res.cmd_byte     = CMD_EXP_WRITE;
                res.obj_index    = wr_index;
                res.obj_subindex = wr_subindex;
                res.data_word    = ev.value_fixed;
                return 1'b1;
            end
            FUNC_RESP: begin
                if (!wr_pending || ev.resp_index != wr_index
                        || ev.resp_subindex != wr_subindex)
                    return 1'b0;
                if (!ev.resp_is_abort)
                    st = STAT_OK;
                else if (ev.resp_error_code == ABORT_RANGE)
                    st = STAT_RANGE;
                else
                    st = STAT_UNKNOWN;
            end
            FUNC_TICK: begin
                if (!wr_pending)
                    return 1'b0;
                if (wr_elapsed != TICKS_MAX)
                    wr_elapsed = wr_elapsed + 16'd1;
                if (wr_elapsed < timeout_q)
                    return 1'b0;
                st = STAT_TIMEOUT;
            end
            default: begin
                wr_pending = 1'b0;
                return 1'b0;
            end
        endcase
        // finish the pending write
        res.out_kind      = KIND_DONE;
        res.done_param_id = wr_param;
        res.done_value    = wr_value;
        res.done_status   = st;
        wr_pending        = 1'b0;
        return 1'b1;
    endfunction

    function automatic item_t make_event(func_t f, logic [15:0] param, logic [31:0] value,
                                         logic [15:0] ridx, logic [7:0] rsub,
                                         logic abort, logic [31:0] code);
        item_t ev;
        ev.func            = f;
        ev.param_id        = param;
        ev.value_fixed     = value;
        ev.resp_index      = ridx;
        ev.resp_subindex   = rsub;
        ev.resp_is_abort   = abort;
        ev.resp_error_code = code;
        return ev;
    endfunction

    // Offer one word, wait for the handshake, then record what it should cause
    task automatic send_event(input item_t ev);
        result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.func;
        s_tdata  <= {7'b0, ev.resp_error_code, ev.resp_is_abort, ev.resp_subindex,
                     ev.resp_index, ev.value_fixed, ev.param_id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (track_write_event(ev, res))
            replies_due.push_back(res);
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic send_simple(func_t f, logic [15:0] param = '0, logic [31:0] value = '0);
        send_event(make_event(f, param, value, '0, '0, 1'b0, '0));
    endtask

    task automatic send_resp(logic [15:0] ridx, logic [7:0] rsub, logic abort,
                             logic [31:0] code);
        send_event(make_event(FUNC_RESP, '0, '0, ridx, rsub, abort, code));
    endtask

    // Stop offering and wait until every expected word is back and the pipe is empty
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_config(logic [6:0] node, logic [10:0] base, logic [15:0] tmo);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_NODE_ID;
        cfg_wdata <= {9'b0, node};
        @(negedge aclk);
        cfg_addr  <= CFG_BASE_ID;
        cfg_wdata <= {5'b0, base};
        @(negedge aclk);
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= tmo;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        node_id_q = node;
        base_id_q = base;
        timeout_q = tmo;
        @(negedge aclk);
    endtask

    // Drive the result side: a counted hold-off wins over random stalls
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("result word with nothing expected: kind %0d, tdata 0x%0h",
                       m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                due = replies_due.pop_front();
                check_field("out_kind",      32'(due.out_kind),      32'(m_tuser));
                check_field("can_id",        32'(due.can_id),        32'(m_tdata[10:0]));
                check_field("cmd_byte",      32'(due.cmd_byte),      32'(m_tdata[18:11]));
                check_field("obj_index",     32'(due.obj_index),     32'(m_tdata[34:19]));
                check_field("obj_subindex",  32'(due.obj_subindex),  32'(m_tdata[42:35]));
                check_field("data_word",     due.data_word,          m_tdata[74:43]);
                check_field("done_param_id", 32'(due.done_param_id), 32'(m_tdata[90:75]));
                check_field("done_value",    due.done_value,         m_tdata[122:91]);
                check_field("done_status",   32'(due.done_status),   32'(m_tdata[124:123]));
            end
        end
    end

    // End the run if no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sdo_expedited_write_tracker_test: done, errors");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_resp(16'h0000, 8'h00, 1'b0, 32'h0);
        send_simple(FUNC_TICK);
        send_simple(FUNC_START, 16'h0000, 32'h0000_0000);
        send_resp(16'h2100, 8'h00, 1'b0, 32'h0);
    endtask

    task automatic test_directed_cases();
        set_config(7'd127, 11'h7FF, 16'd3);
        send_simple(FUNC_START, 16'hFFFF, 32'h7FFF_FFFF);
        send_simple(FUNC_START, 16'h0000, 32'h0);           // refused while busy
        send_resp(16'h21FF, 8'hFE, 1'b1, ABORT_RANGE);      // wrong subindex
        send_resp(16'h21FE, 8'hFF, 1'b1, ABORT_RANGE);      // wrong index
        send_resp(16'h21FF, 8'hFF, 1'b1, ABORT_RANGE);      // out of range abort
        send_simple(FUNC_START, 16'h1234, 32'h8000_0000);
        send_resp(16'h2112, 8'h34, 1'b1, 32'hFFFF_FFFF);    // any other abort
        send_resp(16'h2112, 8'h34, 1'b0, 32'h0);            // response while idle
        send_simple(FUNC_CLEAR);
        send_simple(FUNC_START, 16'h00FF, 32'hFFFF_FFFF);
        send_simple(FUNC_CLEAR);                            // drop it silently
        send_resp(16'h2100, 8'hFF, 1'b0, 32'h0);
        send_simple(FUNC_START, 16'hABCD, 32'h0000_0020);
        send_resp(16'h21AB, 8'hCD, 1'b0, ABORT_RANGE);      // not an abort: ok
        send_simple(FUNC_START, 16'h5555, 32'h0000_0001);
        send_simple(FUNC_TICK);
        send_simple(FUNC_TICK);
        send_simple(FUNC_START, 16'h0101, 32'h0);
        send_simple(FUNC_TICK);                             // reaches the timeout
        send_simple(FUNC_TICK);                             // tick while idle
        set_config(7'd0, 11'h000, 16'd1);
        send_simple(FUNC_START, 16'hFF00, 32'hFFFF_FFFF);
        send_simple(FUNC_TICK);
    endtask

    task automatic test_timeout_limit();
        set_config(7'h2A, 11'h600, 16'd0);
        send_simple(FUNC_CLEAR);
        send_simple(FUNC_START, 16'h2222, 32'h1357_9BDF);
        send_simple(FUNC_TICK);                             // zero timeout fails at once
        set_config(7'h2A, 11'h600, 16'd25);
        send_simple(FUNC_START, 16'h3333, 32'hFFFF_FFE0);
        repeat (24) send_simple(FUNC_TICK);
        send_simple(FUNC_TICK);                             // reaches the timeout
    endtask

    task automatic test_backpressure();
        set_config(7'h05, 11'h580, 16'd40);
        rx_hold_left = 300;
        send_simple(FUNC_CLEAR);
        send_simple(FUNC_START, 16'($urandom_range(16'hFFFF)), $urandom);
        repeat (30) send_simple(FUNC_START, 16'($urandom_range(16'hFFFF)), $urandom);
        wait_results_drained();
        send_resp(wr_index, wr_subindex, 1'b0, 32'h0);
    endtask

    // One write from start to its end, with ticks and stray words in between
    task automatic run_write_sequence();
        int n;
        int pick;
        int bitpos;
        send_simple(FUNC_START, 16'($urandom_range(16'hFFFF)), $urandom);
        n = $urandom_range(0, timeout_q + 1);
        repeat (n) begin
            pick = $urandom_range(99);
            bitpos = $urandom_range(23);
            if (pick < 10)
                send_simple(FUNC_START, 16'($urandom_range(16'hFFFF)), $urandom);
            else if (pick < 20)
                send_resp(wr_index ^ ((bitpos < 16) ? (16'h1 << bitpos) : 16'h0),
                          wr_subindex ^ ((bitpos >= 16) ? (8'h1 << (bitpos - 16)) : 8'h0),
                          1'($urandom_range(1)), $urandom);
            else
                send_simple(FUNC_TICK);
        end
        pick = $urandom_range(99);
        if (pick < 60)
            send_resp(wr_index, wr_subindex, 1'($urandom_range(1)),
                      $urandom_range(1) ? ABORT_RANGE : $urandom);
        else if (pick < 80)
            send_simple(FUNC_CLEAR);
    endtask

    task automatic test_random_traffic(int tx_idle, int rx_idle, int count);
        int stop_at;
        item_t ev;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                ev = make_event(func_t'($urandom_range(3)),
                                16'($urandom_range(16'hFFFF)), $urandom,
                                16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
                                1'($urandom_range(1)), $urandom);
                send_event(ev);
            end else begin
                run_write_sequence();
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 59;
        test_reset_defaults();
        test_directed_cases();
        test_timeout_limit();
        test_backpressure();

        set_config(7'd127, 11'h000, 16'd1);
        test_random_traffic(22, 59, 130);
        set_config(7'($urandom_range(127)), 11'($urandom_range(2047)),
                   16'($urandom_range(2, 16)));
        test_random_traffic(59, 22, 130);
        set_config(7'd0, 11'h7FF, 16'd8);
        test_random_traffic(0, 0, 130);

        wait_results_drained();
        if (mismatch_count == 0)
            $display("sdo_expedited_write_tracker_test: done, clean");
        else
            $display("sdo_expedited_write_tracker_test: done, errors");
        $finish;
    end

endmodule
